>>> design/rtp_pkg.sv
package rtp_pkg;

  // Configuration register indexes.
  typedef enum logic {
    CFG_DIGITS     = 1'b0,
    CFG_VALUE_TYPE = 1'b1
  } cfg_idx_t;

  // Integer type codes.
  typedef enum logic [1:0] {
    TYPE_INT8  = 2'd0,
    TYPE_INT16 = 2'd1,
    TYPE_INT32 = 2'd2,
    TYPE_INT64 = 2'd3
  } value_type_t;

  // Per-item information that travels along the pipeline.
  typedef struct packed {
    logic        is_valid;
    logic        neg;
    logic        bypass;
    logic        zero;
    logic [4:0]  digits;
    logic [6:0]  width;
    logic [63:0] value;
    logic [63:0] mag;
  } side_t;

  // Ten to the power d; digit counts past nineteen map to one, and those items
  // never use the quotient.
  function automatic logic [63:0] pow10(input logic [4:0] d);
    logic [63:0] p;
    case (d)
      5'd0:    p = 64'd1;
      5'd1:    p = 64'd10;
      5'd2:    p = 64'd100;
      5'd3:    p = 64'd1000;
      5'd4:    p = 64'd10000;
      5'd5:    p = 64'd100000;
      5'd6:    p = 64'd1000000;
      5'd7:    p = 64'd10000000;
      5'd8:    p = 64'd100000000;
      5'd9:    p = 64'd1000000000;
      5'd10:   p = 64'd10000000000;
      5'd11:   p = 64'd100000000000;
      5'd12:   p = 64'd1000000000000;
      5'd13:   p = 64'd10000000000000;
      5'd14:   p = 64'd100000000000000;
      5'd15:   p = 64'd1000000000000000;
      5'd16:   p = 64'd10000000000000000;
      5'd17:   p = 64'd100000000000000000;
      5'd18:   p = 64'd1000000000000000000;
      5'd19:   p = 64'd10000000000000000000;
      default: p = 64'd1;
    endcase
    return p;
  endfunction

  // Largest digit count that a type accepts.
  function automatic logic [4:0] max_digits(input value_type_t t);
    logic [4:0] m;
    case (t)
      TYPE_INT8:  m = 5'd2;
      TYPE_INT16: m = 5'd4;
      TYPE_INT32: m = 5'd9;
      TYPE_INT64: m = 5'd19;
      default:    m = 5'd19;
    endcase
    return m;
  endfunction

  // Bit width of a type.
  function automatic logic [6:0] type_bits(input value_type_t t);
    logic [6:0] b;
    case (t)
      TYPE_INT8:  b = 7'd8;
      TYPE_INT16: b = 7'd16;
      TYPE_INT32: b = 7'd32;
      TYPE_INT64: b = 7'd64;
      default:    b = 7'd64;
    endcase
    return b;
  endfunction

endpackage

>>> design/round_int_to_power_of_ten.sv
// Throughput: one item per cycle; busy stays low and start may be held high.
// The depth comes from a 64-step restoring divider, one quotient bit a stage.
// The receiver cannot stall, so nothing in the pipeline ever waits.
// Synchronous reset drops all items in flight and sets digits to 0, type to int64.
module round_int_to_power_of_ten #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  input  logic                          in_is_valid,
  output logic                          out_strobe,
  output logic signed [VALUE_WIDTH-1:0] out_rounded,
  output logic                          out_result_valid,
  output logic                          out_saturated,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [4:0]                    cfg_data
);

  localparam int         STAGES = 64;
  localparam logic [6:0] VW     = 7'(VALUE_WIDTH);

  // Configuration registers.
  logic [4:0]           digits_r;
  rtp_pkg::value_type_t type_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digits_r <= 5'd0;
      type_r   <= rtp_pkg::TYPE_INT64;
    end else if (cfg_valid && cfg_ready) begin
      case (rtp_pkg::cfg_idx_t'(cfg_index))
        rtp_pkg::CFG_DIGITS:     digits_r <= cfg_data;
        rtp_pkg::CFG_VALUE_TYPE: type_r   <= rtp_pkg::value_type_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  // Input register, with the configuration captured alongside each item.
  logic                          in_vld_r;
  logic signed [VALUE_WIDTH-1:0] in_value_r;
  logic                          in_isv_r;
  logic [4:0]                    in_digits_r;
  rtp_pkg::value_type_t          in_type_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    in_value_r  <= in_value;
    in_isv_r    <= in_is_valid;
    in_digits_r <= digits_r;
    in_type_r   <= type_r;
  end

  // Sign-extend from the type width and take the magnitude.
  logic [63:0]    x64;
  logic [6:0]     tbits;
  logic [6:0]     width;
  logic           sign_bit;
  logic [63:0]    v_ext;
  rtp_pkg::side_t side0;

  always_comb begin
    x64   = 64'($signed(in_value_r));
    tbits = rtp_pkg::type_bits(in_type_r);
    width = (tbits > VW) ? VW : tbits;
    sign_bit = x64[6'(width - 7'd1)];
    for (int i = 0; i < 64; i++) begin
      v_ext[i] = (7'(i) < width) ? x64[i] : sign_bit;
    end
    side0.is_valid = in_isv_r;
    side0.neg      = v_ext[63];
    side0.bypass   = (in_digits_r == 5'd0);
    side0.zero     = (in_digits_r > rtp_pkg::max_digits(in_type_r));
    side0.digits   = in_digits_r;
    side0.width    = width;
    side0.value    = v_ext;
    side0.mag      = v_ext[63] ? (64'd0 - v_ext) : v_ext;
  end

  // Divider chain: stage k resolves quotient bit 63-k.
  logic           div_vld  [0:STAGES];
  rtp_pkg::side_t div_side [0:STAGES];
  logic [63:0]    div_q    [0:STAGES];
  logic [63:0]    div_rem  [0:STAGES];

  assign div_vld[0]  = in_vld_r;
  assign div_side[0] = side0;
  assign div_q[0]    = 64'd0;
  assign div_rem[0]  = 64'd0;

  for (genvar k = 0; k < STAGES; k++) begin : g_div
    rtp_div_stage #(
      .BIT (STAGES - 1 - k)
    ) u_stage (
      .clk        (clk),
      .rst_n      (rst_n),
      .in_vld     (div_vld[k]),
      .in_side    (div_side[k]),
      .in_q       (div_q[k]),
      .in_rem     (div_rem[k]),
      .out_vld_r  (div_vld[k+1]),
      .out_side_r (div_side[k+1]),
      .out_q_r    (div_q[k+1]),
      .out_rem_r  (div_rem[k+1])
    );
  end

  // Rounding decision: half-even on the remainder, and the truncated multiple.
  logic [63:0]    rnd_div;
  logic [64:0]    rem_x2;
  logic           up_nxt;
  logic [63:0]    trunc_nxt;
  logic           rnd_vld_r;
  rtp_pkg::side_t rnd_side_r;
  logic           rnd_up_r;
  logic [63:0]    rnd_trunc_r;

  always_comb begin
    rnd_div   = rtp_pkg::pow10(div_side[STAGES].digits);
    rem_x2    = {div_rem[STAGES], 1'b0};
    up_nxt    = (rem_x2 > {1'b0, rnd_div}) ||
                ((rem_x2 == {1'b0, rnd_div}) && div_q[STAGES][0]);
    trunc_nxt = div_side[STAGES].mag - div_rem[STAGES];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_vld_r <= 1'b0;
    end else begin
      rnd_vld_r <= div_vld[STAGES];
    end
  end

  always_ff @(posedge clk) begin
    rnd_side_r  <= div_side[STAGES];
    rnd_up_r    <= up_nxt;
    rnd_trunc_r <= trunc_nxt;
  end

  // Add one step when rounding up, then clamp to the type range.
  logic [63:0]    sat_div;
  logic [65:0]    sum;
  logic [65:0]    lim;
  logic [63:0]    mag_nxt;
  logic           clamp_nxt;
  logic           sat_vld_r;
  rtp_pkg::side_t sat_side_r;
  logic [63:0]    sat_mag_r;
  logic           sat_flag_r;

  always_comb begin
    sat_div = rtp_pkg::pow10(rnd_side_r.digits);
    sum     = {2'b00, rnd_trunc_r} + (rnd_up_r ? {2'b00, sat_div} : 66'd0);
    lim     = {2'b00, (64'd1 << (rnd_side_r.width - 7'd1)) - 64'd1};
    if (!rnd_side_r.neg && (sum > lim)) begin
      mag_nxt   = lim[63:0];
      clamp_nxt = 1'b1;
    end else if (rnd_side_r.neg && (sum > lim + 66'd1)) begin
      mag_nxt   = lim[63:0] + 64'd1;
      clamp_nxt = 1'b1;
    end else begin
      mag_nxt   = sum[63:0];
      clamp_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_vld_r <= 1'b0;
    end else begin
      sat_vld_r <= rnd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    sat_side_r <= rnd_side_r;
    sat_mag_r  <= mag_nxt;
    sat_flag_r <= clamp_nxt;
  end

  // Apply the sign and the special cases, then register the result.
  logic [63:0] res_nxt;
  logic        flag_nxt;
  logic        strobe_r;
  logic [63:0] res_r;
  logic        isv_r;
  logic        flag_r;

  always_comb begin
    if (!sat_side_r.is_valid) begin
      res_nxt  = 64'd0;
      flag_nxt = 1'b0;
    end else if (sat_side_r.bypass) begin
      res_nxt  = sat_side_r.value;
      flag_nxt = 1'b0;
    end else if (sat_side_r.zero) begin
      res_nxt  = 64'd0;
      flag_nxt = 1'b0;
    end else begin
      res_nxt  = sat_side_r.neg ? (64'd0 - sat_mag_r) : sat_mag_r;
      flag_nxt = sat_flag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= sat_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    res_r  <= res_nxt;
    isv_r  <= sat_side_r.is_valid;
    flag_r <= flag_nxt;
  end

  assign out_strobe       = strobe_r;
  assign out_rounded      = res_r[VALUE_WIDTH-1:0];
  assign out_result_valid = isv_r;
  assign out_saturated    = flag_r;

  // A clamp only happens on a present element.
  a_sat_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_saturated |-> out_result_valid)
    else $error("saturated flag on a null item");

  // A null item always comes out as zero.
  a_null_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_result_valid |-> (out_rounded == '0) && !out_saturated)
    else $error("null item with nonzero result");

  // A clamped result sits at a type bound, which is never zero.
  a_sat_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_saturated |-> out_rounded != '0)
    else $error("saturated result is zero");

  // The clamp stage feeds the output register, so its item reaches the output in the next cycle.
  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    sat_vld_r |=> out_strobe)
    else $error("item lost at the output stage");

endmodule

>>> design/rtp_div_stage.sv
module rtp_div_stage #(
  parameter int BIT = 63
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  rtp_pkg::side_t      in_side,
  input  logic [63:0]         in_q,
  input  logic [63:0]         in_rem,
  output logic                out_vld_r,
  output rtp_pkg::side_t      out_side_r,
  output logic [63:0]         out_q_r,
  output logic [63:0]         out_rem_r
);

  logic [63:0] divisor;
  logic [64:0] trial;
  logic [64:0] diff;
  logic        fits;
  logic [63:0] rem_nxt;
  logic [63:0] q_nxt;

  // One restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    divisor = rtp_pkg::pow10(in_side.digits);
    trial   = {in_rem, in_side.mag[BIT]};
    diff    = trial - {1'b0, divisor};
    fits    = (trial >= {1'b0, divisor});
    rem_nxt = fits ? diff[63:0] : trial[63:0];
    q_nxt   = {in_q[62:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_side_r <= in_side;
    out_q_r    <= q_nxt;
    out_rem_r  <= rem_nxt;
  end

endmodule
